### design/mscb_pkg.sv
// Package for the midpoint segment/box clip unit.
// Shared types, outcode bits, clip codes, register indexes and geometry helpers.
// No dependencies.
`timescale 1ns / 1ps

package mscb_pkg;

	// stack of pending half segments
	localparam int STACK_DEPTH = 18;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// outcode bits
	localparam logic [5:0] OC_XHI = 6'h08;
	localparam logic [5:0] OC_XLO = 6'h04;
	localparam logic [5:0] OC_YHI = 6'h02;
	localparam logic [5:0] OC_YLO = 6'h01;
	localparam logic [5:0] OC_ZHI = 6'h20;
	localparam logic [5:0] OC_ZLO = 6'h10;
	localparam logic [5:0] OC_NONE = 6'h00;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	typedef enum logic [1:0] {
		CODE_REJECT  = 2'd0,
		CODE_BOTH_IN = 2'd1,
		CODE_A_IN    = 2'd2,
		CODE_B_IN    = 2'd3
	} clip_code_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec3_t;

	typedef struct packed {
		vec3_t lo;
		vec3_t hi;
	} box_t;

	// one pending half segment on the stack
	typedef struct packed {
		vec3_t start_pt;
		vec3_t end_pt;
	} entry_t;

	// input beat as handed to the engine
	typedef struct packed {
		vec3_t a;
		vec3_t b;
		logic  want;
	} seg_t;

	typedef struct packed {
		clip_code_t code;
		vec3_t      pt;
	} result_t;

	typedef struct packed {
		logic             busy;
		logic [LVL_W-1:0] level;
	} status_t;

	function automatic logic [5:0] outcode(vec3_t p, box_t bx);
		logic [5:0] f;
		f = OC_NONE;
		if (p.x > bx.hi.x) f = f | OC_XHI;
		else if (p.x < bx.lo.x) f = f | OC_XLO;
		if (p.y > bx.hi.y) f = f | OC_YHI;
		else if (p.y < bx.lo.y) f = f | OC_YLO;
		if (p.z > bx.hi.z) f = f | OC_ZHI;
		else if (p.z < bx.lo.z) f = f | OC_ZLO;
		return f;
	endfunction

	// floor((p+q)/2) per coordinate; 17-bit sum, drop the low bit
	function automatic vec3_t midpoint(vec3_t p, vec3_t q);
		logic [16:0] sx;
		logic [16:0] sy;
		logic [16:0] sz;
		vec3_t       m;
		sx = {p.x[15], p.x} + {q.x[15], q.x};
		sy = {p.y[15], p.y} + {q.y[15], q.y};
		sz = {p.z[15], p.z} + {q.z[15], q.z};
		m.x = sx[16:1];
		m.y = sy[16:1];
		m.z = sz[16:1];
		return m;
	endfunction

endpackage

### design/midpoint_segment_box_clip_unit.sv
// Top level of the midpoint segment/box clip unit: box registers, engine, result register.
// Depends on mscb_pkg, mscb_engine (which holds mscb_ram).
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | a_x a_y a_z b_x b_y b_z find_point
//  output   | out_valid/out_stall | clip_code point_x point_y point_z
//  config   | cfg_we              | cfg_idx cfg_wdata
//
// One segment at a time. A trivial case goes from the evaluation state to the finish state,
// where the result register takes it when free and the engine returns to idle for the next
// beat. Each split level pushes a half in the evaluation state; each backtrack also passes
// the load state, as the stack RAM read is registered. Each bisection step is a midpoint,
// then an outcode test, up to about 17 steps. A new segment is taken while a result waits.
// Reset clears the box to zero and the control state; the stack RAM is not cleared.
`timescale 1ns / 1ps

module midpoint_segment_box_clip_unit import mscb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic               find_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         clip_code,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic signed [15:0] point_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	box_t    box_q;
	seg_t    seg;
	result_t eng_res;
	result_t res_q;
	status_t status;
	logic    eng_done;
	logic    res_take;
	logic    out_valid_q;
	logic    start;

	// box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_X: box_q.lo.x <= cfg_wdata;
				REG_MIN_Y: box_q.lo.y <= cfg_wdata;
				REG_MIN_Z: box_q.lo.z <= cfg_wdata;
				REG_MAX_X: box_q.hi.x <= cfg_wdata;
				REG_MAX_Y: box_q.hi.y <= cfg_wdata;
				REG_MAX_Z: box_q.hi.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = status.busy;
	assign start    = in_valid && !in_stall;

	assign seg.a.x  = a_x;
	assign seg.a.y  = a_y;
	assign seg.a.z  = a_z;
	assign seg.b.x  = b_x;
	assign seg.b.y  = b_y;
	assign seg.b.z  = b_z;
	assign seg.want = find_point;

	mscb_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.box      (box_q),
		.start    (start),
		.seg      (seg),
		.res_take (res_take),
		.res_done (eng_done),
		.res      (eng_res),
		.status   (status)
	);

	// result register; free when empty or being taken this cycle
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_done && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done && res_take) begin
			res_q <= eng_res;
		end
	end

	assign out_valid = out_valid_q;
	assign clip_code = res_q.code;
	assign point_x   = res_q.pt.x;
	assign point_y   = res_q.pt.y;
	assign point_z   = res_q.pt.z;

	// no crossing point reported for rejected or fully inside segments
	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (clip_code == CODE_REJECT || clip_code == CODE_BOTH_IN)
		|-> point_x == '0 && point_y == '0 && point_z == '0)
		else $error("point set for a code without a crossing");

	// an accepted beat keeps the engine busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("engine idle right after accepting a beat");

	// the stack never holds more than its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.level <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	// a rejection only comes once the stack of pending halves is empty
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done && eng_res.code == CODE_REJECT |-> status.level == '0)
		else $error("rejected with halves still pending");

endmodule

### design/mscb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mscb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 18,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/mscb_engine.sv
// Clip sequencer: outcode tests, depth-first split over a stack RAM, bisection.
// Depends on mscb_pkg and mscb_ram.
`timescale 1ns / 1ps

module mscb_engine import mscb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  box_t    box,
	input  logic    start,
	input  seg_t    seg,
	input  logic    res_take,
	output logic    res_done,
	output result_t res,
	output status_t status
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_LOAD  = 6'b000100,
		S_BMID  = 6'b001000,
		S_BTEST = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [LVL_W-1:0] level_q;
	vec3_t            a_q;
	vec3_t            b_q;
	vec3_t            ins_q;
	vec3_t            outs_q;
	vec3_t            mid_q;
	logic             want_q;
	clip_code_t       code_q;
	vec3_t            pt_q;

	logic [5:0]       fa;
	logic [5:0]       fb;
	logic [5:0]       fm;
	vec3_t            h;
	logic             pop_cond;
	logic [LVL_W-1:0] level_dec;
	logic             wr_en;
	logic             rd_en;
	entry_t           wr_entry;
	logic [$bits(entry_t)-1:0] rd_raw;
	entry_t           rd_entry;

	// shared geometry for the segment under test and for the bisection midpoint
	always_comb begin
		fa        = outcode(a_q, box);
		fb        = outcode(b_q, box);
		fm        = outcode(mid_q, box);
		h         = midpoint(a_q, b_q);
		pop_cond  = ((fa & fb) != OC_NONE) || (h == a_q) || (h == b_q);
		level_dec = level_q - 1'b1;
		wr_entry.start_pt = h;
		wr_entry.end_pt   = b_q;
		rd_entry  = entry_t'(rd_raw);
	end

	// stack strobes; a pop always comes in a later cycle than the matching push
	assign wr_en = (state_q == S_EVAL) && (fa != OC_NONE) && (fb != OC_NONE) && !pop_cond
		&& (level_q < LVL_W'(STACK_DEPTH));
	assign rd_en = (state_q == S_EVAL) && (fa != OC_NONE) && (fb != OC_NONE) && pop_cond
		&& (level_q != '0);

	mscb_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (level_q[ADDR_W-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (level_dec[ADDR_W-1:0]),
		.rd_data (rd_raw)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			level_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
						level_q <= '0;
					end
				end
				S_EVAL: begin
					if (fa == OC_NONE || fb == OC_NONE) begin
						if (fa != OC_NONE || fb != OC_NONE) begin
							state_q <= want_q ? S_BMID : S_FIN;
						end else begin
							state_q <= S_FIN;
						end
					end else if (pop_cond) begin
						if (level_q == '0) begin
							state_q <= S_FIN;
						end else begin
							level_q <= level_dec;
							state_q <= S_LOAD;
						end
					end else if (wr_en) begin
						level_q <= level_q + 1'b1;
					end
				end
				S_LOAD:  state_q <= S_EVAL;
				S_BMID:  state_q <= S_BTEST;
				S_BTEST: begin
					if (mid_q == ins_q || mid_q == outs_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_BMID;
					end
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					a_q    <= seg.a;
					b_q    <= seg.b;
					want_q <= seg.want;
					pt_q   <= '0;
					code_q <= CODE_REJECT;
				end
			end
			S_EVAL: begin
				if (fa == OC_NONE && fb == OC_NONE) begin
					code_q <= CODE_BOTH_IN;
				end else if (fb == OC_NONE) begin
					code_q <= CODE_B_IN;
					ins_q  <= b_q;
					outs_q <= a_q;
				end else if (fa == OC_NONE) begin
					code_q <= CODE_A_IN;
					ins_q  <= a_q;
					outs_q <= b_q;
				end else if (pop_cond) begin
					code_q <= CODE_REJECT;
				end else begin
					b_q <= h;
				end
			end
			S_LOAD: begin
				a_q <= rd_entry.start_pt;
				b_q <= rd_entry.end_pt;
			end
			S_BMID: mid_q <= midpoint(ins_q, outs_q);
			S_BTEST: begin
				if (mid_q == ins_q || mid_q == outs_q) begin
					pt_q <= mid_q;
				end else if (fm == OC_NONE) begin
					ins_q <= mid_q;
				end else begin
					outs_q <= mid_q;
				end
			end
			default: ;
		endcase
	end

	assign res_done      = (state_q == S_FIN);
	assign res.code      = code_q;
	assign res.pt        = pt_q;
	assign status.busy   = (state_q != S_IDLE);
	assign status.level  = level_q;

endmodule
